// ===== rtl/core/ardd_pkg.sv =====
package ardd_pkg;

  // Fixed point format of the Rice parameter estimate
  localparam int FRAC_BITS = 16;
  localparam int MAX_K = 31;
  localparam int K_W = 5;
  localparam int K_EST_W = K_W + FRAC_BITS;

  // Datapath widths
  localparam int BYTE_W = 8;
  localparam int BIT_CNT_W = 4;
  localparam int Q_W = 32;
  localparam int CNT_W = 32;
  localparam int SAMPLE_W = 16;
  localparam int LEN_W = 13;
  localparam int KEEP_W = 16;
  localparam int KP_W = K_EST_W + KEEP_W;
  localparam int ADAPT_SUM_W = FRAC_BITS + 23;
  localparam int DQ_SCALE_W = 23;
  localparam int DQ_PROD_W = SAMPLE_W + DQ_SCALE_W;
  localparam int DQ_SUM_W = DQ_PROD_W + 1;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_K = 2'd1;
  localparam logic [K_W-1:0] INITIAL_K_RESET = 5'd3;

  // Adaptation coefficients, Q16: 0.99 and 0.01 / 1.55
  localparam logic [KEEP_W-1:0] ADAPT_KEEP = 16'd64881;
  localparam logic [8:0] ADAPT_LEN = 9'd423;
  localparam logic [LEN_W-1:0] LEN_CLAMP = 13'd8191;

  // Dequantizer, Q16: scale 64.061577, offset 31.034184 plus rounding half
  localparam logic [DQ_SCALE_W-1:0] DQ_SCALE = 23'd4198340;
  localparam logic [21:0] DQ_ROUND = 22'd2066624;

  localparam logic [K_EST_W-1:0] K_EST_CAP = K_EST_W'(MAX_K) << FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_CODE,
    ST_MUL,
    ST_DQ,
    ST_PUSH,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load_byte;
    logic bit_step;
    logic code_step;
    logic mul_step;
    logic dq_step;
    logic push_pend;
    logic flush_pend;
  } cmd_t;

  typedef struct packed {
    logic byte_done;
    logic count_reached;
    logic code_done;
    logic pend_valid;
    logic out_free;
  } status_t;

  function automatic logic [K_W-1:0] clamp_k(input logic [K_W-1:0] k);
    clamp_k = (32'(k) > MAX_K) ? K_W'(MAX_K) : k;
  endfunction

endpackage

// ===== rtl/core/ardd_ctrl.sv =====
module ardd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ardd_pkg::status_t status,
  output ardd_pkg::cmd_t    cmd,
  output logic              in_stall
);

  ardd_pkg::state_t state_r;
  ardd_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ardd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ardd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ardd_pkg::ST_BIT;
        end
      end
      ardd_pkg::ST_BIT: begin
        if (status.byte_done || status.count_reached) begin
          state_nxt = ardd_pkg::ST_FLUSH;
        end else if (status.code_done) begin
          state_nxt = ardd_pkg::ST_CODE;
        end
      end
      ardd_pkg::ST_CODE: state_nxt = ardd_pkg::ST_MUL;
      ardd_pkg::ST_MUL:  state_nxt = ardd_pkg::ST_DQ;
      ardd_pkg::ST_DQ:   state_nxt = ardd_pkg::ST_PUSH;
      ardd_pkg::ST_PUSH: begin
        if (!status.pend_valid || status.out_free) begin
          state_nxt = ardd_pkg::ST_BIT;
        end
      end
      ardd_pkg::ST_FLUSH: begin
        if (!status.pend_valid || status.out_free) begin
          state_nxt = ardd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ardd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      ardd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load_byte = in_valid;
      end
      ardd_pkg::ST_BIT: begin
        cmd.bit_step = !(status.byte_done || status.count_reached);
      end
      ardd_pkg::ST_CODE: cmd.code_step = 1'b1;
      ardd_pkg::ST_MUL:  cmd.mul_step = 1'b1;
      ardd_pkg::ST_DQ:   cmd.dq_step = 1'b1;
      ardd_pkg::ST_PUSH: begin
        cmd.push_pend = !status.pend_valid || status.out_free;
      end
      ardd_pkg::ST_FLUSH: begin
        cmd.flush_pend = status.pend_valid && status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/ardd_datapath.sv =====
module ardd_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ardd_pkg::cmd_t                   cmd,
  output ardd_pkg::status_t                status,
  input  logic [ardd_pkg::BYTE_W-1:0]      in_byte,
  input  logic                             cfg_we,
  input  logic [ardd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ardd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [ardd_pkg::SAMPLE_W-1:0]    out_sample,
  output logic                             out_last_in_run,
  output logic                             out_final_sample
);

  // Control state (reset)
  logic [ardd_pkg::K_EST_W-1:0]   k_est_r, k_est_nxt;
  logic [ardd_pkg::Q_W-1:0]       prev_q_r, prev_q_nxt;
  logic [ardd_pkg::Q_W-1:0]       zr_r, zr_nxt;
  logic                           in_rem_r, in_rem_nxt;
  logic [ardd_pkg::K_W-1:0]       rbd_r, rbd_nxt;
  logic [ardd_pkg::Q_W-1:0]       rv_r, rv_nxt;
  logic [ardd_pkg::CNT_W-1:0]     done_cnt_r, done_cnt_nxt;
  logic [ardd_pkg::CNT_W-1:0]     sample_count_r, sample_count_nxt;
  logic [ardd_pkg::BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic                           pend_valid_r, pend_valid_nxt;
  logic                           out_valid_r, out_valid_nxt;

  // Payload
  logic [ardd_pkg::BYTE_W-1:0]      byte_r, byte_nxt;
  logic [ardd_pkg::K_W-1:0]         k_code_r, k_code_nxt;
  logic [ardd_pkg::LEN_W-1:0]       len_r, len_nxt;
  logic [ardd_pkg::KP_W-1:0]        kp_r, kp_nxt;
  logic [ardd_pkg::DQ_PROD_W-1:0]   dq_prod_r, dq_prod_nxt;
  logic [ardd_pkg::SAMPLE_W-1:0]    res_sample_r, res_sample_nxt;
  logic                             res_final_r, res_final_nxt;
  logic [ardd_pkg::SAMPLE_W-1:0]    pend_sample_r, pend_sample_nxt;
  logic                             pend_final_r, pend_final_nxt;
  logic [ardd_pkg::SAMPLE_W-1:0]    out_sample_r, out_sample_nxt;
  logic                             out_last_r, out_last_nxt;
  logic                             out_final_r, out_final_nxt;

  logic [ardd_pkg::K_W-1:0]         k_cur;
  logic                             bit_in;
  logic [ardd_pkg::K_W-1:0]         rbd_inc;
  logic                             code_done;
  logic [ardd_pkg::Q_W-1:0]         rem_mask;
  logic [ardd_pkg::Q_W-1:0]         uval;
  logic [ardd_pkg::Q_W-1:0]         resid;
  logic [ardd_pkg::LEN_W:0]         len_sum;
  logic [ardd_pkg::ADAPT_SUM_W-1:0] adapt_sum;
  logic [ardd_pkg::ADAPT_SUM_W-1:0] est;
  logic [ardd_pkg::SAMPLE_W-1:0]    dq_mag;
  logic [ardd_pkg::DQ_SUM_W-1:0]    dq_sum;
  logic [ardd_pkg::SAMPLE_W-1:0]    dq_r16;
  logic                             out_free;

  assign k_cur = ardd_pkg::clamp_k(k_est_r[ardd_pkg::K_EST_W-1:ardd_pkg::FRAC_BITS]);
  assign bit_in = byte_r[0];
  assign rbd_inc = rbd_r + 1'b1;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (!in_rem_r) begin
      code_done = bit_in && (k_cur == '0);
    end else begin
      code_done = (rbd_inc >= k_cur) || (rbd_inc == '0);
    end
  end

  // Code value, residual and code length
  assign rem_mask = ~({ardd_pkg::Q_W{1'b1}} << k_code_r);
  assign uval = (zr_r << k_code_r) | (rv_r & rem_mask);
  assign resid = uval[0] ? ~(uval >> 1) : (uval >> 1);
  assign len_sum = (ardd_pkg::LEN_W + 1)'(zr_r[ardd_pkg::LEN_W-1:0]) + 1'b1
                   + (ardd_pkg::LEN_W + 1)'(k_code_r);

  // Estimate update: (k_est * keep + (len * 423) << FRAC) >> 16, saturated
  assign adapt_sum = ardd_pkg::ADAPT_SUM_W'(kp_r)
                   + ((ardd_pkg::ADAPT_SUM_W'(len_r) * ardd_pkg::ADAPT_SUM_W'(ardd_pkg::ADAPT_LEN))
                      << ardd_pkg::FRAC_BITS);
  assign est = adapt_sum >> 16;

  // Dequantizer: fold negative codes onto their one's complement magnitude
  assign dq_mag = prev_q_r[ardd_pkg::SAMPLE_W-1] ? ~prev_q_r[ardd_pkg::SAMPLE_W-1:0]
                                                 : prev_q_r[ardd_pkg::SAMPLE_W-1:0];
  assign dq_sum = ardd_pkg::DQ_SUM_W'(dq_prod_r) + ardd_pkg::DQ_SUM_W'(ardd_pkg::DQ_ROUND);
  assign dq_r16 = dq_sum[16 +: ardd_pkg::SAMPLE_W];

  always_comb begin
    k_est_nxt = k_est_r;
    prev_q_nxt = prev_q_r;
    zr_nxt = zr_r;
    in_rem_nxt = in_rem_r;
    rbd_nxt = rbd_r;
    rv_nxt = rv_r;
    done_cnt_nxt = done_cnt_r;
    sample_count_nxt = sample_count_r;
    bit_cnt_nxt = bit_cnt_r;
    pend_valid_nxt = pend_valid_r;
    byte_nxt = byte_r;
    k_code_nxt = k_code_r;
    len_nxt = len_r;
    kp_nxt = kp_r;
    dq_prod_nxt = dq_prod_r;
    res_sample_nxt = res_sample_r;
    res_final_nxt = res_final_r;
    pend_sample_nxt = pend_sample_r;
    pend_final_nxt = pend_final_r;
    out_sample_nxt = out_sample_r;
    out_last_nxt = out_last_r;
    out_final_nxt = out_final_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cmd.load_byte) begin
      byte_nxt = in_byte;
      bit_cnt_nxt = '0;
    end

    // One stream bit per step
    if (cmd.bit_step) begin
      byte_nxt = byte_r >> 1;
      bit_cnt_nxt = bit_cnt_r + 1'b1;
      k_code_nxt = k_cur;
      if (!in_rem_r) begin
        if (!bit_in) begin
          if (zr_r != {ardd_pkg::Q_W{1'b1}}) begin
            zr_nxt = zr_r + 1'b1;
          end
        end else if (k_cur != '0) begin
          in_rem_nxt = 1'b1;
          rbd_nxt = '0;
          rv_nxt = '0;
        end
      end else begin
        rv_nxt = rv_r | (ardd_pkg::Q_W'(bit_in) << rbd_r);
        rbd_nxt = rbd_inc;
      end
    end

    // Close the code: accumulate residual, start adaptation product
    if (cmd.code_step) begin
      prev_q_nxt = prev_q_r + resid;
      if ((zr_r[ardd_pkg::Q_W-1:ardd_pkg::LEN_W] != '0)
          || (len_sum > (ardd_pkg::LEN_W + 1)'(ardd_pkg::LEN_CLAMP))) begin
        len_nxt = ardd_pkg::LEN_CLAMP;
      end else begin
        len_nxt = len_sum[ardd_pkg::LEN_W-1:0];
      end
      kp_nxt = ardd_pkg::KP_W'(k_est_r) * ardd_pkg::KP_W'(ardd_pkg::ADAPT_KEEP);
      zr_nxt = '0;
      in_rem_nxt = 1'b0;
      rbd_nxt = '0;
      rv_nxt = '0;
      done_cnt_nxt = done_cnt_r + 1'b1;
    end

    if (cmd.mul_step) begin
      dq_prod_nxt = ardd_pkg::DQ_PROD_W'(dq_mag) * ardd_pkg::DQ_PROD_W'(ardd_pkg::DQ_SCALE);
      if (est > ardd_pkg::ADAPT_SUM_W'(ardd_pkg::K_EST_CAP)) begin
        k_est_nxt = ardd_pkg::K_EST_CAP;
      end else begin
        k_est_nxt = est[ardd_pkg::K_EST_W-1:0];
      end
    end

    if (cmd.dq_step) begin
      res_sample_nxt = prev_q_r[ardd_pkg::SAMPLE_W-1] ? ~dq_r16 : dq_r16;
      res_final_nxt = (done_cnt_r == sample_count_r);
    end

    // Hold newest result back until we know whether it ends the byte
    if (cmd.push_pend) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_sample_nxt = pend_sample_r;
        out_last_nxt = 1'b0;
        out_final_nxt = pend_final_r;
      end
      pend_valid_nxt = 1'b1;
      pend_sample_nxt = res_sample_r;
      pend_final_nxt = res_final_r;
    end

    if (cmd.flush_pend) begin
      out_valid_nxt = 1'b1;
      out_sample_nxt = pend_sample_r;
      out_last_nxt = 1'b1;
      out_final_nxt = pend_final_r;
      pend_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        ardd_pkg::REG_SAMPLE_COUNT: begin
          sample_count_nxt = cfg_wdata[ardd_pkg::CNT_W-1:0];
        end
        ardd_pkg::REG_INITIAL_K: begin
          k_est_nxt = ardd_pkg::K_EST_W'(ardd_pkg::clamp_k(cfg_wdata[ardd_pkg::K_W-1:0]))
                      << ardd_pkg::FRAC_BITS;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_est_r <= ardd_pkg::K_EST_W'(ardd_pkg::clamp_k(ardd_pkg::INITIAL_K_RESET))
                 << ardd_pkg::FRAC_BITS;
      prev_q_r <= '0;
      zr_r <= '0;
      in_rem_r <= 1'b0;
      rbd_r <= '0;
      rv_r <= '0;
      done_cnt_r <= '0;
      sample_count_r <= '0;
      bit_cnt_r <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      k_est_r <= k_est_nxt;
      prev_q_r <= prev_q_nxt;
      zr_r <= zr_nxt;
      in_rem_r <= in_rem_nxt;
      rbd_r <= rbd_nxt;
      rv_r <= rv_nxt;
      done_cnt_r <= done_cnt_nxt;
      sample_count_r <= sample_count_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    k_code_r <= k_code_nxt;
    len_r <= len_nxt;
    kp_r <= kp_nxt;
    dq_prod_r <= dq_prod_nxt;
    res_sample_r <= res_sample_nxt;
    res_final_r <= res_final_nxt;
    pend_sample_r <= pend_sample_nxt;
    pend_final_r <= pend_final_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r <= out_last_nxt;
    out_final_r <= out_final_nxt;
  end

  assign status.byte_done = (bit_cnt_r == ardd_pkg::BIT_CNT_W'(ardd_pkg::BYTE_W));
  assign status.count_reached = (done_cnt_r >= sample_count_r);
  assign status.code_done = code_done;
  assign status.pend_valid = pend_valid_r;
  assign status.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last_in_run = out_last_r;
  assign out_final_sample = out_final_r;

endmodule

// ===== rtl/core/adaptive_rice_delta_dequant_decoder.sv =====
// Adaptive Rice decoder with delta accumulation and dequantization. Each
// input transaction carries one byte of the compressed stream, consumed bit
// 0 first. A Rice code is a run of zeros, a one, then k remainder bits (LSB
// first); the zigzag residual is summed into a 32-bit quantized value whose
// low 16 bits are scaled by 64.061577 plus 31.034184 (mirrored for negative
// values) into a signed 16-bit sample. k adapts after every code from its
// length, in Q5.16. A byte produces zero to eight output transactions;
// last_in_run marks the last one of a byte and final_sample marks sample
// number sample_count, after which further bits are ignored.
// Timing: the bit loop walks one stream bit per cycle, pausing while a finished
// code passes the residual adder, the adaptation and dequantizer multipliers
// and the result hold stage in turn; the hold stage waits while the output
// side stalls. One byte is decoded at a time; the last result of a byte sits
// in the output register while the next byte is accepted.
// Configuration: cfg_ready is always high. Write only while no byte is in
// flight. Index 0 is sample_count, index 1 is initial_k (also reloads the
// k estimate); other indexes are ignored.
module adaptive_rice_delta_dequant_decoder (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // compressed byte stream
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [ardd_pkg::BYTE_W-1:0]            in_byte,
  // decoded samples
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ardd_pkg::SAMPLE_W-1:0]   out_sample,
  output logic                                   out_last_in_run,
  output logic                                   out_final_sample,
  // register writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ardd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ardd_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  ardd_pkg::cmd_t    cmd;
  ardd_pkg::status_t status;
  logic [ardd_pkg::SAMPLE_W-1:0] sample_bits;

  // Register writes never stall
  assign cfg_ready = 1'b1;

  ardd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  ardd_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_byte          (in_byte),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_sample       (sample_bits),
    .out_last_in_run  (out_last_in_run),
    .out_final_sample (out_final_sample)
  );

  // Present the sample as two's complement
  assign out_sample = $signed(sample_bits);

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // Register indexes that the block decodes to nothing
  localparam logic [ardd_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [ardd_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Decoder arithmetic in Q16
  localparam int          K_FRAC      = 16;
  localparam logic [31:0] K_EST_MAX   = 32'd31 << K_FRAC;
  localparam logic [63:0] KEEP_Q16    = 64'd64881;
  localparam logic [63:0] LEN_Q16     = 64'd423;
  localparam logic [63:0] LEN_MAX     = 64'd8191;
  localparam logic [63:0] DEQ_SCALE   = 64'd4198340;
  localparam logic [63:0] DEQ_OFFSET  = 64'd2033856;
  localparam logic [63:0] DEQ_HALF    = 64'd32768;

  // Settle time for the last byte in flight, and a watchdog limit
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct {
    logic [7:0] bits;
    bit         drain_first;
  } stream_item_t;

  typedef struct {
    logic signed [15:0] sample;
    logic               last_in_run;
    logic               final_sample;
  } sample_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [15:0] out_sample;
  logic        out_last_in_run;
  logic        out_final_sample;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [ardd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ardd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Stimulus and expectations
  stream_item_t stream_queue[$];
  stream_item_t next_item;
  sample_rec_t  expected_samples[$];
  sample_rec_t  head_sample;
  int           sender_idle_pct = 0;
  int           receiver_idle_pct = 0;
  int           mismatches = 0;
  int           cycle_count = 0;

  // Decoder state as the block should hold it
  logic [31:0] sample_limit;
  logic [31:0] k_est;
  logic [31:0] quant_acc;
  logic [31:0] zero_run;
  logic        in_rem;
  logic [4:0]  rem_bits;
  logic [31:0] rem_val;
  logic [31:0] samples_done;

  adaptive_rice_delta_dequant_decoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_last_in_run  (out_last_in_run),
    .out_final_sample (out_final_sample),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("tb: mismatch on %s at cycle %0d: got %0h, want %0h", what, cycle_count, got,
             want);
    mismatches++;
  endtask

  // Scale the low 16 bits of the quantized sum; negative values mirror the
  // positive curve through one's complement.
  function automatic logic [15:0] scale_to_sample(input logic [15:0] c);
    logic [15:0] mag;
    logic [63:0] d;
    mag = c[15] ? 16'hFFFF - c : c;
    d = (64'(mag) * DEQ_SCALE + DEQ_OFFSET + DEQ_HALF) >> 16;
    return c[15] ? ~d[15:0] : d[15:0];
  endfunction

  // End the current code: zigzag residual into the sum, adapt k from the
  // code length, clear the code state.
  task automatic close_rice_code(input int unsigned k, output logic [15:0] smp);
    logic [63:0] mask;
    logic [63:0] len;
    logic [63:0] est;
    logic [31:0] uval;
    logic [31:0] resid;
    mask = (64'd1 << k) - 64'd1;
    uval = (zero_run << k) | (rem_val & mask[31:0]);
    resid = uval[0] ? ~(uval >> 1) : (uval >> 1);
    len = 64'(zero_run) + 64'd1 + 64'(k);
    quant_acc = quant_acc + resid;
    if (len > LEN_MAX) len = LEN_MAX;
    est = (64'(k_est) * KEEP_Q16 + ((len * LEN_Q16) << K_FRAC)) >> 16;
    k_est = (est > 64'(K_EST_MAX)) ? K_EST_MAX : est[31:0];
    zero_run = '0;
    in_rem = 1'b0;
    rem_bits = '0;
    rem_val = '0;
    samples_done = samples_done + 32'd1;
    smp = scale_to_sample(quant_acc[15:0]);
  endtask

  // Walk one byte bit by bit, LSB first, and queue the samples it ends.
  task automatic rice_decode_byte(input logic [7:0] bits);
    int unsigned k;
    bit          done;
    int          n;
    logic [15:0] smp;
    sample_rec_t recs[8];
    n = 0;
    for (int i = 0; i < 8; i++) begin
      k = k_est >> K_FRAC;
      done = 1'b0;
      if (samples_done >= sample_limit) break;
      if (!in_rem) begin
        if (!bits[i]) begin
          if (zero_run != 32'hFFFF_FFFF) zero_run = zero_run + 32'd1;
        end else if (k == 0) begin
          done = 1'b1;
        end else begin
          in_rem = 1'b1;
          rem_bits = '0;
          rem_val = '0;
        end
      end else begin
        rem_val = rem_val | (32'(bits[i]) << rem_bits);
        rem_bits = rem_bits + 5'd1;
        // k is read at every bit, so a smaller k ends an open code at once
        if (rem_bits >= k || rem_bits == 0) done = 1'b1;
      end
      if (done) begin
        close_rice_code(k, smp);
        recs[n].sample = smp;
        recs[n].last_in_run = 1'b0;
        recs[n].final_sample = (samples_done == sample_limit);
        n++;
      end
    end
    if (n > 0) recs[n-1].last_in_run = 1'b1;
    for (int i = 0; i < n; i++) expected_samples.push_back(recs[i]);
  endtask

  task automatic queue_byte(input logic [7:0] bits, input bit drain_first = 1'b0);
    stream_item_t item;
    item.bits = bits;
    item.drain_first = drain_first;
    stream_queue.push_back(item);
  endtask

  // Mix of densities so k moves over its whole range
  function automatic logic [7:0] pick_stream_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom);
      4, 5:       return 8'($urandom & $urandom & $urandom);
      6:          return 8'($urandom | $urandom);
      7:          return 8'h00;
      8:          return 8'hFF;
      default:    return 8'h01 << $urandom_range(0, 7);
    endcase
  endfunction

  // Write one register while the decoder is idle and mirror it locally.
  task automatic write_reg(input logic [ardd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == ardd_pkg::REG_SAMPLE_COUNT) begin
      sample_limit = data;
    end else if (idx == ardd_pkg::REG_INITIAL_K) begin
      // a 5-bit k never exceeds the cap of 31
      k_est = {11'd0, data[4:0], 16'd0};
    end
    cfg_valid <= 1'b0;
  endtask

  // Wait until every byte is taken and every sample has come back, then let
  // trailing bits of the last byte run out.
  task automatic settle();
    while (stream_queue.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: predict on each accepted transaction, then offer the next byte
  // unless the sender idles or a drain point holds it back.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) rice_decode_byte(in_byte);
      if (!in_valid || !in_stall) begin
        if (stream_queue.size() != 0 &&
            !(stream_queue[0].drain_first && expected_samples.size() != 0) &&
            $urandom_range(0, 99) >= sender_idle_pct) begin
          next_item = stream_queue.pop_front();
          in_valid <= 1'b1;
          in_byte <= next_item.bits;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted sample with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        flag_mismatch("unexpected sample", out_sample, 0);
      end else begin
        head_sample = expected_samples.pop_front();
        if (out_sample !== head_sample.sample)
          flag_mismatch("sample", out_sample, head_sample.sample);
        if (out_last_in_run !== head_sample.last_in_run)
          flag_mismatch("last_in_run", out_last_in_run, head_sample.last_in_run);
        if (out_final_sample !== head_sample.final_sample)
          flag_mismatch("final_sample", out_final_sample, head_sample.final_sample);
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < receiver_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int chunk_items;
    int hold_at;
    // reset values
    sample_limit = '0;
    k_est = {11'd0, ardd_pkg::INITIAL_K_RESET, 16'd0};
    quant_acc = '0;
    zero_run = '0;
    in_rem = 1'b0;
    rem_bits = '0;
    rem_val = '0;
    samples_done = '0;
    sender_idle_pct = 25;
    receiver_idle_pct = 50;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // sample_count comes out of reset at zero: these bytes decode nothing
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'h5A);
    settle();

    // unused indexes must change nothing
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    write_reg(ardd_pkg::REG_SAMPLE_COUNT, 32'hFFFF_FFFF);
    write_reg(ardd_pkg::REG_INITIAL_K, 32'd0);
    // k of zero: every one bit is a whole code, eight samples in one byte
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'h80);
    queue_byte(8'h01);
    queue_byte(8'h55);
    queue_byte(8'hAA);
    settle();

    // all-ones data masks down to k = 31; long remainders span bytes
    write_reg(ardd_pkg::REG_INITIAL_K, 32'hFFFF_FFFF);
    queue_byte(8'h01);
    repeat (4) queue_byte(8'hFF);
    queue_byte(8'h7F);
    // long zero run at a large k, so the code value wraps at 32 bits
    repeat (16) queue_byte(8'h00);
    queue_byte(8'h01);
    repeat (4) queue_byte(8'hFF);
    settle();

    // open a code at k = 31, then shrink k while it sits in its remainder
    write_reg(ardd_pkg::REG_INITIAL_K, 32'd31);
    queue_byte(8'h01);
    settle();
    write_reg(ardd_pkg::REG_INITIAL_K, 32'h0000_0024);
    queue_byte(8'hF0);
    queue_byte(8'h3C);
    queue_byte(8'h96, 1'b1);
    settle();

    // count reached in the middle of a byte, the rest of the bits dropped
    write_reg(ardd_pkg::REG_INITIAL_K, 32'd0);
    write_reg(ardd_pkg::REG_SAMPLE_COUNT, samples_done + 32'd5);
    queue_byte(8'hFF);
    queue_byte(8'hFF);
    settle();
    write_reg(ardd_pkg::REG_SAMPLE_COUNT, samples_done + 32'd1);
    queue_byte(8'h00);
    queue_byte(8'h10);
    settle();

    // Random part in four chunks, each with its own k; the first three also set
    // their own idle pattern, and the last one stops at a sample count partway through.
    for (int chunk = 0; chunk < 4; chunk++) begin
      chunk_items = (chunk == 3) ? 50 : 55;
      hold_at = $urandom_range(10, chunk_items - 10);
      case (chunk)
        0: begin
          sender_idle_pct = 25;
          receiver_idle_pct = 50;
          write_reg(ardd_pkg::REG_SAMPLE_COUNT, 32'hFFFF_FFFF);
          write_reg(ardd_pkg::REG_INITIAL_K, 32'd3);
        end
        1: begin
          sender_idle_pct = 50;
          receiver_idle_pct = 25;
          write_reg(ardd_pkg::REG_INITIAL_K, $urandom);
        end
        2: begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
          write_reg(ardd_pkg::REG_INITIAL_K, 32'd31);
        end
        default: begin
          write_reg(ardd_pkg::REG_INITIAL_K, $urandom_range(0, 31));
          write_reg(ardd_pkg::REG_SAMPLE_COUNT, samples_done + 32'd60);
        end
      endcase
      for (int n = 0; n < chunk_items; n++) queue_byte(pick_stream_byte(), n == hold_at);
      settle();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ardd_pkg.sv
rtl/core/ardd_ctrl.sv
rtl/core/ardd_datapath.sv
rtl/core/adaptive_rice_delta_dequant_decoder.sv
test/testbench.sv
